// File: src/dpw_pkg.sv
package dpw_pkg;

  // Quarter turn in Q30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Divisors of the sine Taylor series terms: (2n)(2n+1) for n = 1..8.
  localparam logic [63:0] TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  localparam logic signed [17:0] SAMPLE_MAX = 18'sd131071;
  localparam logic signed [17:0] SAMPLE_MIN = -18'sd131072;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } dpw_div_stat_t;

  // Sine of a Q30 angle in [0, pi/2], rounded to Q15. Used at elaboration only.
  function automatic logic [15:0] sine_round(logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 0; n < 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    return 16'((64'(sum) + 64'd16384) >> 15);
  endfunction

endpackage

// File: src/dpw_mul.sv
module dpw_mul #(
  parameter int A_W = 36,
  parameter int B_W = 22
) (
  input  logic                 clk,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic [A_W+B_W-1:0]   p_r
);

  // Registered unsigned product; the result is valid in the cycle after the operands.
  always_ff @(posedge clk) begin
    p_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

// File: src/dpw_div.sv
module dpw_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 44,
  parameter int QW    = 32,
  parameter int CNT_W = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]      den,
  input  logic [CNT_W-1:0]      nbits,
  output logic [QW-1:0]         quot,
  output dpw_pkg::dpw_div_stat_t stat
);

  // Restoring division, one numerator bit per cycle. The numerator arrives
  // left-aligned and nbits gives how many of its bits to consume.
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [QW-1:0]    q_r;
  logic             ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  assign trial   = {rem_r, num_r[NUM_W-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r <= num;
        den_r <= den;
        rem_r <= '0;
        q_r   <= '0;
        ovf_r <= 1'b0;
        cnt_r <= nbits;
      end else if (cnt_r != '0) begin
        num_r <= num_r << 1;
        rem_r <= rem_nxt;
        q_r   <= {q_r[QW-2:0], ge};
        ovf_r <= ovf_r | q_r[QW-1];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot      = q_r;
  assign stat.busy = cnt_r != '0;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

// File: src/dpw_sine_rom.sv
module dpw_sine_rom #(
  parameter int DEPTH = 256
) (
  input  logic                         clk,
  input  logic [$clog2(DEPTH+1)-1:0]   addr,
  output logic [15:0]                  data_r
);

  // Quarter-wave table with DEPTH+1 entries, built at elaboration.
  logic [15:0] rom [0:DEPTH];

  for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
    localparam logic [63:0] X_Q30 = (dpw_pkg::HALF_PI_Q30 * 64'(k)) / DEPTH;
    assign rom[k] = dpw_pkg::sine_round(X_Q30);
  end

  always_ff @(posedge clk) begin
    data_r <= rom[addr];
  end

endmodule

// File: src/dpw_antialiased_oscillator_core.sv
// The core takes one request at a time: in_ready is high only in ST_IDLE, and a
// finished sample waits in ST_FIN while the output register is stalled. Unless the
// sample rate is zero or the selector silent, the bit-serial divider runs once for
// the phase step (PHASE_BITS+18 bits) and, for ramp, pulse and triangle at a nonzero
// frequency, once for the output scale (60 bits).
// Reset (synchronous, active low): sample rate 44100, sine selected, phases and
// previous parabolas cleared except the second phase at half a cycle.
module dpw_antialiased_oscillator_core #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [20:0]        in_freq_sixteenth_hz,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] out_sample,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [17:0]        cfg_wdata
);

  // Widths of the datapath. The step numerator is the 22-bit frequency shifted
  // up by PHASE_BITS-4; the scale numerator is at most 60 bits wide.
  localparam int PB      = PHASE_BITS;
  localparam int STEP_NW = PB + 18;
  localparam int SC_NW   = 60;
  localparam int NUM_W   = (STEP_NW > SC_NW) ? STEP_NW : SC_NW;
  localparam int QW      = (PB > 18) ? PB : 18;
  localparam int DEN_W   = 44;
  localparam int CNT_W   = $clog2(NUM_W + 1);
  localparam int MA_W    = ((PB - 2) > 36) ? (PB - 2) : 36;
  localparam int MB_W    = 22;
  localparam int P_W     = MA_W + MB_W;
  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);

  localparam logic [0:0] REG_SAMPLE_RATE = 1'b0;
  localparam logic [0:0] REG_WAVE_SELECT = 1'b1;

  localparam logic [2:0] WAVE_SINE  = 3'd0;
  localparam logic [2:0] WAVE_PULSE = 3'd2;
  localparam logic [2:0] WAVE_TRI   = 3'd3;

  // The sequencer walks one request through the shared multiplier and divider.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIN_MUL,
    ST_SIN_IDX,
    ST_SIN_RD,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_PAR1,
    ST_PAR1R,
    ST_PAR2R,
    ST_DIFF,
    ST_M_FSQ,
    ST_M_NUM,
    ST_M_DEN,
    ST_DIV_SC,
    ST_SC_WAIT,
    ST_FIN
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [17:0] fs_cfg_r;
  logic [2:0]  sel_cfg_r;

  // Oscillator state.
  logic [PB-1:0]      main_phase_r;
  logic [PB-1:0]      second_phase_r;
  logic signed [17:0] prev_par_r;
  logic signed [17:0] prev_sec_r;
  logic               sq_flag_r;

  // Per-request working registers.
  logic [17:0]        fs_r;
  logic [2:0]         sel_r;
  logic [21:0]        f_r;
  logic [16:0]        s_r;
  logic [16:0]        s2_r;
  logic signed [17:0] d_r;
  logic [16:0]        d_mag;
  logic [SC_NW-1:0]   num_r;
  logic signed [17:0] y_r;
  logic signed [17:0] out_sample_r;
  logic               out_valid_r;

  // Shared units.
  logic [MA_W-1:0]        mul_a;
  logic [MB_W-1:0]        mul_b;
  logic [P_W-1:0]         mul_p;
  logic                   div_start;
  logic [NUM_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den;
  logic [CNT_W-1:0]       div_nbits;
  logic [QW-1:0]          div_quot;
  dpw_pkg::dpw_div_stat_t div_stat;
  logic [IDX_W-1:0]       rom_addr;
  logic [15:0]            rom_data;

  // Input clamp: the frequency stays below half the sample rate, i.e. under 8*fs
  // in sixteenths of a hertz. Triangle runs the accumulator at twice the rate.
  logic [20:0] fmax;
  logic [20:0] f_clamp;
  logic [21:0] f_eff;

  assign fmax    = {fs_cfg_r, 3'b000} - 21'd1;
  assign f_clamp = (in_freq_sixteenth_hz > fmax) ? fmax : in_freq_sixteenth_hz;
  assign f_eff   = (sel_cfg_r == WAVE_TRI) ? {f_clamp, 1'b0} : {1'b0, f_clamp};

  // Magnitude of the bipolar phase taken from the top 16 phase bits.
  function automatic logic [15:0] abs_bipolar(logic [15:0] t);
    return t[15] ? {1'b0, t[14:0]} : 16'(17'd32768 - {1'b0, t});
  endfunction

  logic [15:0] ub_main;
  logic [15:0] ub_second;
  logic [16:0] par_now;

  assign ub_main   = abs_bipolar(main_phase_r[PB-1 -: 16]);
  assign ub_second = abs_bipolar(second_phase_r[PB-1 -: 16]);
  // Parabola in Q15, rounded: (b*b + 2^14) >> 15.
  assign par_now   = 17'((mul_p[31:0] + 32'd16384) >> 15);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SIN_MUL: begin
        mul_a = MA_W'(main_phase_r[PB-3:0]);
        mul_b = MB_W'(SINE_TABLE_DEPTH);
      end
      ST_PAR1: begin
        mul_a = MA_W'(ub_main);
        mul_b = MB_W'(ub_main);
      end
      ST_PAR1R: begin
        mul_a = MA_W'(ub_second);
        mul_b = MB_W'(ub_second);
      end
      ST_M_FSQ: begin
        mul_a = MA_W'(fs_r);
        mul_b = MB_W'(fs_r);
      end
      ST_M_NUM: begin
        mul_a = MA_W'(mul_p[35:0]);
        mul_b = MB_W'(d_mag);
      end
      ST_M_DEN: begin
        mul_a = MA_W'(f_r);
        mul_b = MB_W'({fs_r, 4'b0000}) - MB_W'(f_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider requests: the phase step floor(F * 2^(PB-4) / fs), then the output
  // scale round(|d| * 64 fs^2 / (F (16 fs - F))). Both numerators are left-aligned.
  logic [STEP_NW-1:0] step_num;
  logic [SC_NW-1:0]   sc_num;

  assign step_num  = {f_r, {(PB-4){1'b0}}};
  assign sc_num    = num_r + SC_NW'(mul_p >> 1);
  assign div_start = (state_r == ST_STEP_GO) || (state_r == ST_DIV_SC);

  always_comb begin
    if (state_r == ST_DIV_SC) begin
      div_num   = NUM_W'(sc_num) << (NUM_W - SC_NW);
      div_den   = DEN_W'(mul_p);
      div_nbits = CNT_W'(SC_NW);
    end else begin
      div_num   = NUM_W'(step_num) << (NUM_W - STEP_NW);
      div_den   = DEN_W'(fs_r);
      div_nbits = CNT_W'(STEP_NW);
    end
  end

  // Sine table address: the quadrant fraction scaled to the table depth, read
  // backwards in the second and fourth quadrants.
  logic [IDX_W-1:0] sin_idx;

  assign sin_idx  = mul_p[PB-2 +: IDX_W];
  assign rom_addr = main_phase_r[PB-2] ? IDX_W'(SINE_TABLE_DEPTH) - sin_idx : sin_idx;

  // Phase advance with the carry out that toggles the triangle's square flag.
  logic [PB-1:0] step;
  logic [PB:0]   main_sum;

  assign step     = div_quot[PB-1:0];
  assign main_sum = {1'b0, main_phase_r} + {1'b0, step};

  // Parabola differences. Triangle modulates 1 - s by the square flag first.
  logic signed [17:0] tri_m;
  logic signed [17:0] d_nxt;
  logic signed [17:0] par_store;

  assign tri_m = sq_flag_r ? 18'sd32768 - signed'({1'b0, s_r})
                           : signed'({1'b0, s_r}) - 18'sd32768;

  always_comb begin
    case (sel_r)
      WAVE_PULSE: begin
        par_store = signed'({1'b0, s_r});
        d_nxt     = (signed'({1'b0, s_r}) - prev_par_r)
                  - (signed'({1'b0, s2_r}) - prev_sec_r);
      end
      WAVE_TRI: begin
        par_store = tri_m;
        d_nxt     = tri_m - prev_par_r;
      end
      default: begin
        par_store = signed'({1'b0, s_r});
        d_nxt     = signed'({1'b0, s_r}) - prev_par_r;
      end
    endcase
  end

  assign d_mag = d_r[17] ? 17'(-d_r) : 17'(d_r);

  // Saturation of the rounded quotient, with the sign of the difference.
  logic               big_neg;
  logic               big_pos;
  logic signed [17:0] y_scaled;

  assign big_neg  = div_stat.ovf || (div_quot > QW'(131072));
  assign big_pos  = div_stat.ovf || (div_quot > QW'(131071));
  assign y_scaled = d_r[17] ? (big_neg ? dpw_pkg::SAMPLE_MIN : -18'(div_quot))
                            : (big_pos ? dpw_pkg::SAMPLE_MAX : 18'(div_quot));

  assign in_ready = (state_r == ST_IDLE);

  // Sequencer, configuration and output register. A finished sample waits in
  // ST_FIN only while the output register still holds an earlier one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      fs_cfg_r       <= 18'd44100;
      sel_cfg_r      <= WAVE_SINE;
      main_phase_r   <= '0;
      second_phase_r <= {1'b1, {(PB-1){1'b0}}};
      prev_par_r     <= '0;
      prev_sec_r     <= '0;
      sq_flag_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLE_RATE: fs_cfg_r  <= cfg_wdata;
          REG_WAVE_SELECT: sel_cfg_r <= cfg_wdata[2:0];
          default: ;
        endcase
      end

      // In ST_FIN the output register is reloaded or left holding its sample.
      if (out_valid_r && out_ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            fs_r  <= fs_cfg_r;
            sel_r <= sel_cfg_r;
            f_r   <= f_eff;
            y_r   <= '0;
            // A zero sample rate or a silent selector leaves the state alone.
            if (fs_cfg_r == '0 || sel_cfg_r > WAVE_TRI) begin
              state_r <= ST_FIN;
            end else if (sel_cfg_r == WAVE_SINE) begin
              state_r <= ST_SIN_MUL;
            end else begin
              state_r <= ST_STEP_GO;
            end
          end
        end
        ST_SIN_MUL: state_r <= ST_SIN_IDX;
        ST_SIN_IDX: state_r <= ST_SIN_RD;
        ST_SIN_RD: begin
          y_r     <= main_phase_r[PB-1] ? -18'(rom_data) : 18'(rom_data);
          state_r <= ST_STEP_GO;
        end
        ST_STEP_GO: state_r <= ST_STEP_WAIT;
        ST_STEP_WAIT: begin
          if (div_stat.done) begin
            main_phase_r <= main_sum[PB-1:0];
            if (sel_r == WAVE_TRI && main_sum[PB]) begin
              sq_flag_r <= ~sq_flag_r;
            end
            if (sel_r == WAVE_PULSE) begin
              second_phase_r <= second_phase_r + step;
            end
            state_r <= (sel_r == WAVE_SINE) ? ST_FIN : ST_PAR1;
          end
        end
        ST_PAR1: state_r <= ST_PAR1R;
        ST_PAR1R: begin
          s_r     <= par_now;
          state_r <= (sel_r == WAVE_PULSE) ? ST_PAR2R : ST_DIFF;
        end
        ST_PAR2R: begin
          s2_r    <= par_now;
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          d_r        <= d_nxt;
          prev_par_r <= par_store;
          if (sel_r == WAVE_PULSE) begin
            prev_sec_r <= signed'({1'b0, s2_r});
          end
          // Zero frequency still updates the parabolas but outputs silence.
          if (f_r == '0) begin
            y_r     <= '0;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_M_FSQ;
          end
        end
        ST_M_FSQ: state_r <= ST_M_NUM;
        ST_M_NUM: state_r <= ST_M_DEN;
        ST_M_DEN: begin
          num_r   <= SC_NW'(mul_p) << 6;
          state_r <= ST_DIV_SC;
        end
        ST_DIV_SC: state_r <= ST_SC_WAIT;
        ST_SC_WAIT: begin
          if (div_stat.done) begin
            y_r     <= y_scaled;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_sample_r <= y_r;
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  dpw_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  dpw_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QW    (QW),
    .CNT_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .nbits (div_nbits),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  dpw_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  // The divider is only started when it is free.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A finished division is only ever seen by a state that waits for it.
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_STEP_WAIT || state_r == ST_SC_WAIT))
    else $error("divider result arrived outside a wait state");

  // The square flag only moves on a phase advance.
  a_flag_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_STEP_WAIT) |=> $stable(sq_flag_r))
    else $error("square flag changed outside a phase advance");

  // The second phase only moves on a pulse-mode phase advance.
  a_second_pulse_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_STEP_WAIT || sel_r != WAVE_PULSE) |=> $stable(second_phase_r))
    else $error("second phase moved outside pulse mode");

endmodule
